FILE: hdl/vau_pkg.sv
// ---------------------------------------------------------------------------
// vau_pkg
// Shared types and codes for the 3-component fixed-point vector unit.
// ---------------------------------------------------------------------------
package vau_pkg;

    localparam logic [31:0] Q_MAX_C = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN_C = 32'h8000_0000;

    typedef enum logic [3:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_NEG    = 4'd2,
        OP_MUL    = 4'd3,
        OP_DIV    = 4'd4,
        OP_SCALE  = 4'd5,
        OP_DIVS   = 4'd6,
        OP_LENGTH = 4'd7,
        OP_NORM   = 4'd8,
        OP_CROSS  = 4'd9,
        OP_DOT    = 4'd10,
        OP_NONE   = 4'd15
    } op_t;

    typedef struct packed {
        logic        [3:0]  kind;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
        logic signed [31:0] factor;
    } req_t;

    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic signed [31:0] scalar_result;
        logic               div_zero;
        logic               saturated;
    } rsp_t;

    // Classified request as it travels from the front to the back
    typedef struct packed {
        op_t              op;
        logic [2:0][31:0] a;
        logic [2:0][31:0] b;
        logic [31:0]      f;
    } cmd_t;

    // Queue status toward the front (full) and the back (not empty)
    typedef struct packed {
        logic not_empty;
        logic full;
    } qstat_t;

endpackage

FILE: hdl/vau_stream_if.sv
// ---------------------------------------------------------------------------
// vau_stream_if
// Valid/ready channel carrying one payload per request.
// ---------------------------------------------------------------------------
interface vau_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/vec3_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// vec3_arithmetic_unit: Q(31-FRAC_BITS).FRAC_BITS vector ALU
// Throughput: one request per cycle while the response channel is ready;
// 32 root stages and 32 + FRAC_BITS divider stages in line. Async
// active-low reset empties all stages.
// ---------------------------------------------------------------------------
module vec3_arithmetic_unit #(
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    vau_stream_if.sink   req,
    vau_stream_if.source rsp
);

    logic            push;
    logic            pop;
    vau_pkg::cmd_t   front_cmd;
    vau_pkg::cmd_t   queue_cmd;
    vau_pkg::qstat_t qstat;

    vau_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .qstat (qstat),
        .push  (push),
        .cmd   (front_cmd)
    );

    vau_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_cmd),
        .pop   (pop),
        .dout  (queue_cmd),
        .qstat (qstat)
    );

    vau_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (qstat.not_empty),
        .cmd       (queue_cmd),
        .pop       (pop),
        .rsp       (rsp)
    );

endmodule

FILE: hdl/vau_front.sv
// ---------------------------------------------------------------------------
// vau_front
// Accepts requests, decodes the opcode and registers the classified request.
// ---------------------------------------------------------------------------
module vau_front (
    input  logic            clk,
    input  logic            rst_n,
    vau_stream_if.sink      req,
    input  vau_pkg::qstat_t qstat,
    output logic            push,
    output vau_pkg::cmd_t   cmd
);

    logic          valid_reg;
    vau_pkg::cmd_t cmd_reg;
    vau_pkg::cmd_t cmd_next;

    assign req.ready = !valid_reg || !qstat.full;
    assign push      = valid_reg && !qstat.full;
    assign cmd       = cmd_reg;

    always_comb
    begin
        cmd_next.op = vau_pkg::OP_NONE;
        if (req.payload.kind <= 4'(vau_pkg::OP_DOT))
        begin
            cmd_next.op = vau_pkg::op_t'(req.payload.kind);
        end
        cmd_next.a[0] = req.payload.ax;
        cmd_next.a[1] = req.payload.ay;
        cmd_next.a[2] = req.payload.az;
        cmd_next.b[0] = req.payload.bx;
        cmd_next.b[1] = req.payload.by;
        cmd_next.b[2] = req.payload.bz;
        cmd_next.f    = req.payload.factor;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

FILE: hdl/vau_fifo.sv
// ---------------------------------------------------------------------------
// vau_fifo
// Short request queue between the front and the back.
// ---------------------------------------------------------------------------
module vau_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  vau_pkg::cmd_t   din,
    input  logic            pop,
    output vau_pkg::cmd_t   dout,
    output vau_pkg::qstat_t qstat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    vau_pkg::cmd_t   mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign qstat.full      = (count_reg == CW'(DEPTH));
    assign qstat.not_empty = (count_reg != '0);
    assign do_push         = push && !qstat.full;
    assign do_pop          = pop && qstat.not_empty;
    assign dout            = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CW'(do_push) - CW'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

FILE: hdl/vau_back.sv
// ---------------------------------------------------------------------------
// vau_back
// Execution pipeline: multipliers, rounding, square root, radix-2 dividers.
// ---------------------------------------------------------------------------
module vau_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    input  vau_pkg::cmd_t cmd,
    output logic          pop,
    vau_stream_if.source  rsp
);

    localparam int NW        = 32 + FRAC_BITS;
    localparam int SQ_STAGES = 32;
    localparam logic signed [65:0] MAX66 = 66'sh0_7FFF_FFFF;
    localparam logic signed [65:0] MIN66 = -MAX66 - 66'sd1;
    localparam logic signed [65:0] HALF  = 66'sd1 <<< (FRAC_BITS - 1);

    typedef struct packed {
        vau_pkg::op_t     op;
        logic [2:0][31:0] a;
        logic [2:0][31:0] b;
        logic [31:0]      f;
        logic [2:0][31:0] r;
        logic [31:0]      s;
        logic             sat;
    } item_t;

    typedef struct packed {
        logic [31:0]   d;
        logic [NW-1:0] n;
        logic [31:0]   rem;
        logic [NW-1:0] q;
        logic          neg;
        logic          nneg;
        logic          nzero;
        logic          dzero;
    } dlane_t;

    function automatic logic [32:0] clamp32(input logic signed [65:0] v);
        priority if (v > MAX66)
            return {1'b1, vau_pkg::Q_MAX_C};
        else if (v < MIN66)
            return {1'b1, vau_pkg::Q_MIN_C};
        else
            return {1'b0, v[31:0]};
    endfunction

    function automatic logic signed [65:0] rnd(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = v + HALF;
        return t >>> FRAC_BITS;
    endfunction

    logic adv;
    logic out_valid_reg;
    vau_pkg::rsp_t rsp_reg;

    assign adv         = !out_valid_reg || rsp.ready;
    assign pop         = adv && pop_valid;
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = rsp_reg;

    // ---------------- stage 1: products ----------------
    logic               v1_reg;
    vau_pkg::cmd_t      c1_reg;
    logic signed [63:0] p0_reg [3];
    logic signed [63:0] p1_reg [3];
    logic signed [63:0] p0_next [3];
    logic signed [63:0] p1_next [3];

    always_comb
    begin
        logic signed [31:0] m0a;
        logic signed [31:0] m0b;
        int j;
        int k;
        for (int i = 0; i < 3; i++)
        begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            unique case (cmd.op)
                vau_pkg::OP_SCALE:
                begin
                    m0a = $signed(cmd.a[i]);
                    m0b = $signed(cmd.f);
                end
                vau_pkg::OP_CROSS:
                begin
                    m0a = $signed(cmd.a[j]);
                    m0b = $signed(cmd.b[k]);
                end
                vau_pkg::OP_LENGTH, vau_pkg::OP_NORM:
                begin
                    m0a = $signed(cmd.a[i]);
                    m0b = $signed(cmd.a[i]);
                end
                default:
                begin
                    m0a = $signed(cmd.a[i]);
                    m0b = $signed(cmd.b[i]);
                end
            endcase
            p0_next[i] = m0a * m0b;
            p1_next[i] = $signed(cmd.a[k]) * $signed(cmd.b[j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= pop_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg <= cmd;
            for (int i = 0; i < 3; i++)
            begin
                p0_reg[i] <= p0_next[i];
                p1_reg[i] <= p1_next[i];
            end
        end
    end

    // ---------------- stage 2: add/sub, rounding, clamp ----------------
    logic        v2_reg;
    item_t       it2_reg;
    logic [63:0] sq2_reg;
    item_t       it2_next;
    logic [63:0] sq2_next;

    always_comb
    begin
        logic signed [65:0] ea;
        logic signed [65:0] eb;
        logic signed [65:0] v;
        logic [32:0]        cl;
        it2_next.op  = c1_reg.op;
        it2_next.a   = c1_reg.a;
        it2_next.b   = c1_reg.b;
        it2_next.f   = c1_reg.f;
        it2_next.sat = 1'b0;
        it2_next.s   = '0;
        for (int i = 0; i < 3; i++)
        begin
            ea = 66'($signed(c1_reg.a[i]));
            eb = 66'($signed(c1_reg.b[i]));
            unique case (c1_reg.op)
                vau_pkg::OP_ADD:                   v = ea + eb;
                vau_pkg::OP_SUB:                   v = ea - eb;
                vau_pkg::OP_NEG:                   v = -ea;
                vau_pkg::OP_MUL, vau_pkg::OP_SCALE: v = rnd(66'(p0_reg[i]));
                vau_pkg::OP_CROSS:                 v = rnd(66'(p0_reg[i]) - 66'(p1_reg[i]));
                default:                           v = '0;
            endcase
            cl             = clamp32(v);
            it2_next.r[i]  = cl[31:0];
            it2_next.sat   = it2_next.sat | cl[32];
        end
        v  = rnd(66'(p0_reg[0]) + 66'(p0_reg[1]) + 66'(p0_reg[2]));
        cl = clamp32(v);
        if (c1_reg.op == vau_pkg::OP_DOT)
        begin
            it2_next.s   = cl[31:0];
            it2_next.sat = cl[32];
        end
        sq2_next = $unsigned(p0_reg[0]) + $unsigned(p0_reg[1]) + $unsigned(p0_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it2_reg <= it2_next;
            sq2_reg <= sq2_next;
        end
    end

    // ---------------- square root: two radicand bits per stage ----------------
    logic        sv_reg    [SQ_STAGES];
    item_t       sit_reg   [SQ_STAGES];
    logic [63:0] sn_reg    [SQ_STAGES];
    logic [33:0] srem_reg  [SQ_STAGES];
    logic [31:0] sroot_reg [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++)
    begin : g_sqrt
        logic        in_v;
        item_t       in_it;
        logic [63:0] in_n;
        logic [33:0] in_rem;
        logic [31:0] in_root;
        logic [35:0] rs;
        logic [35:0] trial;

        if (k == 0)
        begin : g_first
            assign in_v    = v2_reg;
            assign in_it   = it2_reg;
            assign in_n    = sq2_reg;
            assign in_rem  = '0;
            assign in_root = '0;
        end
        else
        begin : g_rest
            assign in_v    = sv_reg[k-1];
            assign in_it   = sit_reg[k-1];
            assign in_n    = sn_reg[k-1];
            assign in_rem  = srem_reg[k-1];
            assign in_root = sroot_reg[k-1];
        end

        assign rs    = {in_rem, in_n[63:62]};
        assign trial = {2'b00, in_root, 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                sv_reg[k] <= in_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sit_reg[k] <= in_it;
                sn_reg[k]  <= {in_n[61:0], 2'b00};
                if (rs >= trial)
                begin
                    srem_reg[k]  <= 34'(rs - trial);
                    sroot_reg[k] <= {in_root[30:0], 1'b1};
                end
                else
                begin
                    srem_reg[k]  <= rs[33:0];
                    sroot_reg[k] <= {in_root[30:0], 1'b0};
                end
            end
        end
    end

    // ---------------- divider setup: signs, magnitudes, length result ----------------
    logic              uv_reg;
    item_t             uit_reg;
    dlane_t [2:0]      ul_reg;
    item_t             uit_next;
    dlane_t [2:0]      ul_next;

    always_comb
    begin
        logic [31:0] len;
        logic [31:0] dsrc;
        logic        dsg;
        logic        dneg;
        logic [31:0] amag;
        len      = sroot_reg[SQ_STAGES-1];
        uit_next = sit_reg[SQ_STAGES-1];
        if (uit_next.op == vau_pkg::OP_LENGTH)
        begin
            if (len[31])
            begin
                uit_next.s   = vau_pkg::Q_MAX_C;
                uit_next.sat = 1'b1;
            end
            else
            begin
                uit_next.s = len;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            unique case (uit_next.op)
                vau_pkg::OP_DIV:
                begin
                    dsrc = uit_next.b[i];
                    dsg  = 1'b1;
                end
                vau_pkg::OP_DIVS:
                begin
                    dsrc = uit_next.f;
                    dsg  = 1'b1;
                end
                default:
                begin
                    dsrc = len;
                    dsg  = 1'b0;
                end
            endcase
            dneg             = dsg & dsrc[31];
            ul_next[i].d     = dneg ? 32'(32'd0 - dsrc) : dsrc;
            ul_next[i].nneg  = uit_next.a[i][31];
            amag             = uit_next.a[i][31] ? 32'(32'd0 - uit_next.a[i]) : uit_next.a[i];
            ul_next[i].n     = {amag, {FRAC_BITS{1'b0}}};
            ul_next[i].nzero = (uit_next.a[i] == '0);
            ul_next[i].dzero = (ul_next[i].d == '0);
            ul_next[i].neg   = uit_next.a[i][31] ^ dneg;
            ul_next[i].rem   = '0;
            ul_next[i].q     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uv_reg <= 1'b0;
        end
        else if (adv)
        begin
            uv_reg <= sv_reg[SQ_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            uit_reg <= uit_next;
            ul_reg  <= ul_next;
        end
    end

    // ---------------- dividers: one quotient bit per stage, three lanes ----------------
    logic         dv_reg  [NW];
    item_t        dit_reg [NW];
    dlane_t [2:0] dl_reg  [NW];

    for (genvar k = 0; k < NW; k++)
    begin : g_div
        logic         in_v;
        item_t        in_it;
        dlane_t [2:0] in_l;
        dlane_t [2:0] out_l;

        if (k == 0)
        begin : g_first
            assign in_v  = uv_reg;
            assign in_it = uit_reg;
            assign in_l  = ul_reg;
        end
        else
        begin : g_rest
            assign in_v  = dv_reg[k-1];
            assign in_it = dit_reg[k-1];
            assign in_l  = dl_reg[k-1];
        end

        always_comb
        begin
            logic [32:0] rs;
            out_l = in_l;
            for (int i = 0; i < 3; i++)
            begin
                rs         = {in_l[i].rem, in_l[i].n[NW-1]};
                out_l[i].n = {in_l[i].n[NW-2:0], 1'b0};
                if (rs >= {1'b0, in_l[i].d})
                begin
                    out_l[i].rem = 32'(rs - {1'b0, in_l[i].d});
                    out_l[i].q   = {in_l[i].q[NW-2:0], 1'b1};
                end
                else
                begin
                    out_l[i].rem = rs[31:0];
                    out_l[i].q   = {in_l[i].q[NW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                dv_reg[k] <= in_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dit_reg[k] <= in_it;
                dl_reg[k]  <= out_l;
            end
        end
    end

    // ---------------- sign, clamp and result select ----------------
    vau_pkg::rsp_t rsp_next;

    always_comb
    begin
        item_t            it;
        dlane_t [2:0]     ln;
        logic [2:0][31:0] r;
        logic             is_div;
        logic             dz;
        logic             sat;
        it     = dit_reg[NW-1];
        ln     = dl_reg[NW-1];
        r      = it.r;
        dz     = 1'b0;
        sat    = it.sat;
        is_div = (it.op == vau_pkg::OP_DIV) || (it.op == vau_pkg::OP_DIVS)
              || (it.op == vau_pkg::OP_NORM);
        if (is_div)
        begin
            for (int i = 0; i < 3; i++)
            begin
                priority if (ln[i].dzero)
                begin
                    dz = 1'b1;
                    if (ln[i].nzero)
                        r[i] = '0;
                    else if (ln[i].nneg)
                        r[i] = vau_pkg::Q_MIN_C;
                    else
                        r[i] = vau_pkg::Q_MAX_C;
                end
                else if (ln[i].neg)
                begin
                    if (ln[i].q > NW'(33'h0_8000_0000))
                    begin
                        r[i] = vau_pkg::Q_MIN_C;
                        sat  = 1'b1;
                    end
                    else
                    begin
                        r[i] = 32'(32'd0 - ln[i].q[31:0]);
                    end
                end
                else
                begin
                    if (ln[i].q > NW'(vau_pkg::Q_MAX_C))
                    begin
                        r[i] = vau_pkg::Q_MAX_C;
                        sat  = 1'b1;
                    end
                    else
                    begin
                        r[i] = ln[i].q[31:0];
                    end
                end
            end
        end
        rsp_next.rx            = r[0];
        rsp_next.ry            = r[1];
        rsp_next.rz            = r[2];
        rsp_next.scalar_result = it.s;
        rsp_next.div_zero      = dz;
        rsp_next.saturated     = sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_reg[NW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

FILE: verif/vau_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vau_checker
// Watches the request and response channels of the vector unit, predicts
// each response from the accepted request and compares it field by field.
// ---------------------------------------------------------------------------
module vau_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    vau_stream_if.sink    req_mon,
    vau_stream_if.sink    rsp_mon,
    output int            fail_count,
    output int            pending
);

    vau_pkg::rsp_t expected_rsps[$];

    function automatic logic signed [31:0] clamp_q(input logic signed [127:0] v,
                                                   inout logic sat);
        if (v > 128'sd2147483647)
        begin
            sat = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -128'sd2147483648)
        begin
            sat = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Round an exact product sum to nearest, ties toward +inf
    function automatic logic signed [31:0] round_q(input logic signed [127:0] v,
                                                   inout logic sat);
        logic signed [127:0] t;
        t = (v + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return clamp_q(t, sat);
    endfunction

    function automatic logic signed [31:0] div_q(input logic signed [127:0] n,
                                                 input logic signed [127:0] d,
                                                 inout logic dz, inout logic sat);
        logic signed [127:0] q;
        if (d == 128'sd0)
        begin
            dz = 1'b1;
            if (n > 128'sd0) return 32'sh7FFF_FFFF;
            if (n < 128'sd0) return 32'sh8000_0000;
            return 32'sd0;
        end
        q = (n <<< FRAC_BITS) / d;
        return clamp_q(q, sat);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] bitv;
        r = '0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 64'd0)
        begin
            if (n >= r + bitv)
            begin
                n = n - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic vau_pkg::rsp_t predict_vec_op(input vau_pkg::req_t q);
        vau_pkg::rsp_t r;
        logic signed [127:0] a[3];
        logic signed [127:0] b[3];
        logic signed [127:0] f;
        logic signed [127:0] acc;
        logic signed [31:0]  cr;
        logic [63:0] sq;
        logic [63:0] len;
        logic dz;
        logic sat;
        int j;
        int k;
        r = '0;
        dz = 1'b0;
        sat = 1'b0;
        a[0] = 128'(q.ax); a[1] = 128'(q.ay); a[2] = 128'(q.az);
        b[0] = 128'(q.bx); b[1] = 128'(q.by); b[2] = 128'(q.bz);
        f = 128'(q.factor);
        case (vau_pkg::op_t'(q.kind))
            vau_pkg::OP_ADD:
            begin
                r.rx = clamp_q(a[0] + b[0], sat);
                r.ry = clamp_q(a[1] + b[1], sat);
                r.rz = clamp_q(a[2] + b[2], sat);
            end
            vau_pkg::OP_SUB:
            begin
                r.rx = clamp_q(a[0] - b[0], sat);
                r.ry = clamp_q(a[1] - b[1], sat);
                r.rz = clamp_q(a[2] - b[2], sat);
            end
            vau_pkg::OP_NEG:
            begin
                r.rx = clamp_q(-a[0], sat);
                r.ry = clamp_q(-a[1], sat);
                r.rz = clamp_q(-a[2], sat);
            end
            vau_pkg::OP_MUL:
            begin
                r.rx = round_q(a[0] * b[0], sat);
                r.ry = round_q(a[1] * b[1], sat);
                r.rz = round_q(a[2] * b[2], sat);
            end
            vau_pkg::OP_DIV:
            begin
                r.rx = div_q(a[0], b[0], dz, sat);
                r.ry = div_q(a[1], b[1], dz, sat);
                r.rz = div_q(a[2], b[2], dz, sat);
            end
            vau_pkg::OP_SCALE:
            begin
                r.rx = round_q(a[0] * f, sat);
                r.ry = round_q(a[1] * f, sat);
                r.rz = round_q(a[2] * f, sat);
            end
            vau_pkg::OP_DIVS:
            begin
                r.rx = div_q(a[0], f, dz, sat);
                r.ry = div_q(a[1], f, dz, sat);
                r.rz = div_q(a[2], f, dz, sat);
            end
            vau_pkg::OP_LENGTH, vau_pkg::OP_NORM:
            begin
                acc = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
                sq = acc[63:0];
                len = int_sqrt(sq);
                if (vau_pkg::op_t'(q.kind) == vau_pkg::OP_LENGTH)
                    r.scalar_result = clamp_q({64'd0, len}, sat);
                else
                begin
                    r.rx = div_q(a[0], {64'd0, len}, dz, sat);
                    r.ry = div_q(a[1], {64'd0, len}, dz, sat);
                    r.rz = div_q(a[2], {64'd0, len}, dz, sat);
                end
            end
            vau_pkg::OP_CROSS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    j = (i + 1) % 3;
                    k = (i + 2) % 3;
                    cr = round_q(a[j] * b[k] - a[k] * b[j], sat);
                    if (i == 0) r.rx = cr;
                    else if (i == 1) r.ry = cr;
                    else r.rz = cr;
                end
            end
            vau_pkg::OP_DOT:
                r.scalar_result = round_q(a[0] * b[0] + a[1] * b[1] + a[2] * b[2], sat);
            default:
                ;
        endcase
        r.div_zero = dz;
        r.saturated = sat;
        return r;
    endfunction

    assign pending = expected_rsps.size();

    always @(posedge clk or negedge rst_n)
    begin
        vau_pkg::rsp_t exp_r;
        vau_pkg::rsp_t act_r;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (req_mon.valid && req_mon.ready)
                expected_rsps.push_back(predict_vec_op(req_mon.payload));
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                act_r = rsp_mon.payload;
                if (expected_rsps.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected response %p", act_r);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_rsps.pop_front();
                    if (act_r.rx !== exp_r.rx || act_r.ry !== exp_r.ry
                        || act_r.rz !== exp_r.rz
                        || act_r.scalar_result !== exp_r.scalar_result
                        || act_r.div_zero !== exp_r.div_zero
                        || act_r.saturated !== exp_r.saturated)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p actual %p", exp_r, act_r);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives directed and random vector requests with random idle bursts on both
// channels and reports the verdict from the checker's failure count.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int FRAC = 16;
    localparam int LATENCY = 69 + FRAC;
    localparam int WATCHDOG_LIMIT = 20 * LATENCY + 200;
    localparam int NUM_RANDOM = 1530;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    bit   calm;

    vau_stream_if #(.payload_t(vau_pkg::req_t)) req_ch ();
    vau_stream_if #(.payload_t(vau_pkg::rsp_t)) rsp_ch ();

    vec3_arithmetic_unit #(.FRAC_BITS(FRAC)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    vau_checker #(.FRAC_BITS(FRAC)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_mon    (req_ch.sink),
        .rsp_mon    (rsp_ch.sink),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #10 clk = ~clk;

    initial
    begin
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
    end

    // Receiver stalls in bursts
    always @(negedge clk)
    begin
        int burst;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            burst = $urandom_range(1, 4);
            rsp_ch.ready <= 1'b0;
            repeat (burst) @(negedge clk);
        end
        rsp_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sd0;
            3: return $signed($urandom_range(0, 4)) - 2;
            4, 5: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            6: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic vau_pkg::req_t random_req();
        vau_pkg::req_t q;
        q.kind   = ($urandom_range(0, 20) == 0) ? 4'($urandom_range(11, 15))
                                                : 4'($urandom_range(0, 10));
        q.ax     = pick_value();
        q.ay     = pick_value();
        q.az     = pick_value();
        q.bx     = pick_value();
        q.by     = pick_value();
        q.bz     = pick_value();
        q.factor = pick_value();
        return q;
    endfunction

    task automatic send_req(input vau_pkg::req_t q);
        int burst;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            burst = $urandom_range(1, 4);
            req_ch.valid <= 1'b0;
            repeat (burst) @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= q;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_vec(input vau_pkg::op_t op, input logic signed [31:0] a0,
                            input logic signed [31:0] a1, input logic signed [31:0] a2,
                            input logic signed [31:0] b0, input logic signed [31:0] b1,
                            input logic signed [31:0] b2, input logic signed [31:0] f);
        vau_pkg::req_t q;
        q.kind = op;
        q.ax = a0; q.ay = a1; q.az = a2;
        q.bx = b0; q.by = b1; q.bz = b2;
        q.factor = f;
        send_req(q);
    endtask

    initial
    begin
        vau_pkg::req_t q;
        int            drain;
        calm = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: every operation plus extremes and zero divisors
        send_vec(vau_pkg::OP_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, 1, -1, 2, 0);
        send_vec(vau_pkg::OP_SUB, 32'sh8000_0000, 32'sh7FFF_FFFF, 5, 1, -1, 7, 0);
        send_vec(vau_pkg::OP_NEG, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0, 0, 0);
        send_vec(vau_pkg::OP_MUL, 32'sh7FFF_FFFF, 32'sh0001_8000, 32'sh0000_8000,
                 32'sh7FFF_FFFF, 32'sh0000_0001, 32'sh0000_0001, 0);
        send_vec(vau_pkg::OP_MUL, -1, 32'shFFFF_8000, 3, 32'sh0000_8000, 1,
                 -32'sh0000_8000, 0);
        send_vec(vau_pkg::OP_DIV, 5, -5, 0, 0, 0, 0, 0);
        send_vec(vau_pkg::OP_DIV, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0003_0000,
                 1, -1, 32'sh0002_0000, 0);
        send_vec(vau_pkg::OP_SCALE, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000,
                 0, 0, 0, 32'sh8000_0000);
        send_vec(vau_pkg::OP_DIVS, 3, -3, 0, 0, 0, 0, 0);
        send_vec(vau_pkg::OP_DIVS, 32'sh7FFF_FFFF, 32'sh8000_0000, 7, 0, 0, 0, 1);
        send_vec(vau_pkg::OP_LENGTH, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                 0, 0, 0, 0);
        send_vec(vau_pkg::OP_LENGTH, 32'sh0003_0000, 32'sh0004_0000, 0, 0, 0, 0, 0);
        send_vec(vau_pkg::OP_NORM, 0, 0, 0, 0, 0, 0, 0);
        send_vec(vau_pkg::OP_NORM, 32'sh0003_0000, -32'sh0004_0000, 0, 0, 0, 0, 0);
        send_vec(vau_pkg::OP_NORM, 1, 0, 0, 0, 0, 0, 0);
        send_vec(vau_pkg::OP_CROSS, 32'sh0001_0000, 0, 0, 0, 32'sh0001_0000, 0, 0);
        send_vec(vau_pkg::OP_CROSS, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
        send_vec(vau_pkg::OP_DOT, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0);
        send_vec(vau_pkg::OP_DOT, 32'sh0000_8000, 32'sh0000_8000, 1, 1, 1,
                 32'sh0000_8000, 0);
        send_vec(vau_pkg::op_t'(4'd11), -1, -1, -1, -1, -1, -1, -1);
        send_vec(vau_pkg::OP_NONE, -1, -1, -1, -1, -1, -1, -1);

        // Hold off until the pipe is empty
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n == NUM_RANDOM - 200)
                calm = 1'b1;
            q = random_req();
            send_req(q);
        end
        req_ch.valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        drain = 0;
        while (drain < LATENCY + 20)
        begin
            @(negedge clk);
            drain++;
        end
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
